>>> rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

>>> rtl/apr_pkg.sv
// shared types, constants and default-color function of the palette block
// no dependencies
`default_nettype none

package apr_pkg;

    // table geometry
    localparam int SMALL_DEPTH = 32;
    localparam int LARGE_DEPTH = 256;
    localparam int COMP_W      = 8;
    localparam int ENTRY_W     = 3 * COMP_W;

    // component values
    localparam logic [COMP_W-1:0]  NIBBLE_MASK = 8'hF0;
    localparam logic [COMP_W-1:0]  LEVEL_HALF  = 8'd128;
    localparam logic [COMP_W-1:0]  LEVEL_FULL  = 8'd255;
    localparam logic [ENTRY_W-1:0] WHITE_ENTRY = {3{LEVEL_FULL}};

    // palette select code of the second 16-color layer
    localparam logic [1:0] SEL_LAYER1 = 2'd2;

    typedef enum logic [1:0] {
        ACT_SET   = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        COMP_RED   = 2'd0,
        COMP_GREEN = 2'd1,
        COMP_BLUE  = 2'd2
    } t_component;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_MERGE = 1'b1
    } t_state;

    // 16-color default, entry layout {red, green, blue}: bit 3 full or half, bit 1 red, bit 2 green, bit 0 blue
    function automatic logic [ENTRY_W-1:0] small_default(input logic [3:0] num);
        logic [COMP_W-1:0] level;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        level = num[3] ? LEVEL_FULL : LEVEL_HALF;
        red   = num[1] ? level : '0;
        green = num[2] ? level : '0;
        blue  = num[0] ? level : '0;
        return {red, green, blue};
    endfunction

endpackage

`default_nettype wire

>>> rtl/analog_palette_register_file.sv
// top level of the palette register file: index latch, control and both tables
// depends on apr_pkg, apr_ram and assert_macros.svh
//
// Usage: one command beat is taken at a rising edge with start high and busy
// low; it carries i_action (set latch, write component, read component),
// i_palette_select, i_component and i_data. Every command gives exactly one
// result beat: o_read_value marked by o_result_strobe for one cycle (zero
// for set and write commands, and for unused action or component codes).
// Timing: the accept edge issues the table read; in the merge cycle the
// component is merged, the entry is written back and the result beat is
// registered to the ports. busy is high for one cycle after each accept, so
// no new command is taken while one is in its merge cycle; the read-modify-write
// on the single ram port is the reason for this.
// Reset (synchronous) clears the index latch and the valid bits of both
// tables; entries never written read as the 16-color defaults of apr_pkg or as
// white in the 256-color table, so no clearing pass is needed.
// The receiver cannot stall: each result is marked by o_result_strobe for one cycle only.
`default_nettype none

module analog_palette_register_file
    import apr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [1:0]  i_palette_select,
    input  wire logic [1:0]  i_component,
    input  wire logic [7:0]  i_data,
    output logic             o_result_strobe,
    output logic      [7:0]  o_read_value
);

    localparam int SMALL_AW = $clog2(SMALL_DEPTH);
    localparam int LARGE_AW = $clog2(LARGE_DEPTH);

    t_state                r_state;
    t_state                n_state;
    logic [LARGE_AW-1:0]   r_index_latch;
    t_action               r_action;
    logic                  r_action_ok;
    t_component            r_comp;
    logic                  r_large;
    logic [COMP_W-1:0]     r_data;
    logic [SMALL_AW-1:0]   r_sm_addr;
    logic                  r_out_strobe;
    logic [COMP_W-1:0]     r_out_value;

    logic                  accept;
    logic [SMALL_AW-1:0]   sm_addr_in;
    logic [SMALL_AW-1:0]   sm_addr;
    logic                  sm_we;
    logic                  lg_we;
    logic [ENTRY_W-1:0]    sm_rdata;
    logic                  sm_rvalid;
    logic [ENTRY_W-1:0]    lg_rdata;
    logic                  lg_rvalid;
    logic [ENTRY_W-1:0]    cur_entry;
    logic [ENTRY_W-1:0]    new_entry;
    logic [COMP_W-1:0]     cur_byte;
    logic [COMP_W-1:0]     wr_byte;
    logic                  comp_ok;
    logic                  do_write;
    logic                  do_read;
    logic [COMP_W-1:0]     n_out_value;

    assign accept = start && !busy;

    // small table slot: layer bit over the low nibble of the latch
    assign sm_addr_in = {i_palette_select == SEL_LAYER1, r_index_latch[3:0]};
    assign sm_addr    = (r_state == ST_MERGE) ? r_sm_addr : sm_addr_in;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshake
    always_comb begin
        n_state = r_state;
        busy    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_MERGE;
                end
            end
            ST_MERGE: begin
                busy    = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // command capture at the accept beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action    <= t_action'(i_action);
            r_action_ok <= (i_action == ACT_SET) || (i_action == ACT_WRITE)
                           || (i_action == ACT_READ);
            r_comp      <= t_component'(i_component);
            r_large     <= i_palette_select[0];
            r_data      <= i_data;
            r_sm_addr   <= sm_addr_in;
        end
    end

    // entry as read, with reset values for entries never written
    always_comb begin
        if (r_large) begin
            cur_entry = lg_rvalid ? lg_rdata : WHITE_ENTRY;
        end else begin
            cur_entry = sm_rvalid ? sm_rdata : small_default(r_sm_addr[3:0]);
        end
    end

    // component value to store
    assign wr_byte = r_large ? r_data : {r_data[7:4], r_data[7:4]};

    // component select and merge
    always_comb begin
        new_entry = cur_entry;
        cur_byte  = '0;
        comp_ok   = 1'b1;
        case (r_comp)
            COMP_RED: begin
                cur_byte            = cur_entry[23:16];
                new_entry[23:16]    = wr_byte;
            end
            COMP_GREEN: begin
                cur_byte            = cur_entry[15:8];
                new_entry[15:8]     = wr_byte;
            end
            COMP_BLUE: begin
                cur_byte            = cur_entry[7:0];
                new_entry[7:0]      = wr_byte;
            end
            default: begin
                comp_ok = 1'b0;
            end
        endcase
    end

    // decode of the merge cycle
    always_comb begin
        do_write = 1'b0;
        do_read  = 1'b0;
        if (r_state == ST_MERGE && r_action_ok) begin
            unique case (r_action)
                ACT_WRITE: do_write = comp_ok;
                ACT_READ:  do_read  = comp_ok;
                default:   begin
                    do_write = 1'b0;
                    do_read  = 1'b0;
                end
            endcase
        end
    end

    assign sm_we = do_write && !r_large;
    assign lg_we = do_write && r_large;

    assign n_out_value = !do_read ? '0
                       : (r_large ? cur_byte : (cur_byte & NIBBLE_MASK));

    // index latch and result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_latch <= '0;
            r_out_strobe  <= 1'b0;
        end else begin
            r_out_strobe <= (r_state == ST_MERGE);
            if (r_state == ST_MERGE && r_action_ok && r_action == ACT_SET) begin
                r_index_latch <= r_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MERGE) begin
            r_out_value <= n_out_value;
        end
    end

    assign o_result_strobe = r_out_strobe;
    assign o_read_value    = r_out_value;

    // 16-color tables, both layers
    apr_ram #(
        .DEPTH (SMALL_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_small_ram (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_re     (accept),
        .i_we     (sm_we),
        .i_addr   (sm_addr),
        .i_wdata  (new_entry),
        .o_rdata  (sm_rdata),
        .o_rvalid (sm_rvalid)
    );

    // 256-color table
    apr_ram #(
        .DEPTH (LARGE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_large_ram (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_re     (accept),
        .i_we     (lg_we),
        .i_addr   (r_index_latch),
        .i_wdata  (new_entry),
        .o_rdata  (lg_rdata),
        .o_rvalid (lg_rvalid)
    );

`include "assert_macros.svh"

    // an accepted beat always leads to the merge cycle
    `ASSERT_NEXT(a_accept_to_merge, i_clk, i_rst_n, i_rst_n && accept, busy)
    // every merge cycle gives exactly one result beat
    `ASSERT_NEXT(a_merge_gives_result, i_clk, i_rst_n, busy, o_result_strobe)
    // a result beat never shows while a command is in the merge cycle
    `ASSERT_IMPLIES(a_result_when_idle, i_clk, i_rst_n, o_result_strobe, !busy)
    // at most one table is written back per command
    `ASSERT_IMPLIES(a_single_table_write, i_clk, i_rst_n, sm_we, !lg_we)

endmodule

`default_nettype wire

>>> rtl/apr_ram.sv
// single-port palette ram with registered read and per-entry valid bits
// depends on apr_pkg for default geometry
`default_nettype none

module apr_ram
    import apr_pkg::*;
#(
    parameter int DEPTH = LARGE_DEPTH,
    parameter int WIDTH = ENTRY_W,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_re,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_rvalid
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rvalid;

    // storage array, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    // valid bits: an entry never written reads as its reset value upstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_addr] <= 1'b1;
            end
            if (i_re) begin
                r_rvalid <= r_valid[i_addr];
            end
        end
    end

    assign o_rdata  = r_rdata;
    assign o_rvalid = r_rvalid;

endmodule

`default_nettype wire

>>> dv/tb.sv
// self-checking testbench for analog_palette_register_file: command beats in, one
// strobed read_value per beat out, checked against a palette predictor held here
// depends on apr_pkg and the rtl of the palette block
`default_nettype none

module tb
    import apr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // codes outside the package enums
    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam logic [1:0] COMP_UNUSED = 2'd3;
    localparam logic [1:0] SEL_LAYER0  = 2'd0;
    localparam logic [1:0] SEL_LARGE   = 2'd1;
    localparam logic [1:0] SEL_LARGE_B = 2'd3;

    localparam int RANDOM_BEATS = 750;
    localparam int DRAIN_LIMIT  = 2000;

    // one beat and the value it should read back
    typedef struct {
        logic [1:0] action;
        logic [1:0] sel;
        logic [1:0] comp;
        logic [7:0] data;
        logic [7:0] read_value;
    } t_palette_access;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] i_action = '0;
    logic [1:0] i_palette_select = '0;
    logic [1:0] i_component = '0;
    logic [7:0] i_data = '0;
    logic       o_result_strobe;
    logic [7:0] o_read_value;

    // predictor state: latch plus both tables, {red, green, blue} per entry
    logic [7:0] latch_model;
    logic [7:0] small_tab [SMALL_DEPTH][3];
    logic [7:0] large_tab [LARGE_DEPTH][3];

    t_palette_access read_values_due [$];
    int  mismatches = 0;
    bit  no_idle = 1'b0;

    analog_palette_register_file dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_palette_select (i_palette_select),
        .i_component      (i_component),
        .i_data           (i_data),
        .o_result_strobe  (o_result_strobe),
        .o_read_value     (o_read_value)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    // reset contents: 16-color defaults in both layers, white in the 256 table
    task automatic reset_palette_model();
        logic [7:0] level;
        latch_model = '0;
        for (int n = 0; n < 16; n++) begin
            level = (n >= 8) ? LEVEL_FULL : LEVEL_HALF;
            for (int layer = 0; layer < 2; layer++) begin
                small_tab[layer*16 + n][0] = n[1] ? level : 8'd0;
                small_tab[layer*16 + n][1] = n[2] ? level : 8'd0;
                small_tab[layer*16 + n][2] = n[0] ? level : 8'd0;
            end
        end
        for (int e = 0; e < LARGE_DEPTH; e++)
            for (int c = 0; c < 3; c++)
                large_tab[e][c] = LEVEL_FULL;
    endtask

    // apply one accepted beat to the model and queue the value it returns
    task automatic predict_access(input logic [1:0] act, input logic [1:0] sel,
                                  input logic [1:0] comp, input logic [7:0] data);
        t_palette_access acc;
        logic [4:0] slot;
        bit to_large;
        to_large = sel[0];
        slot = {sel == SEL_LAYER1, latch_model[3:0]};
        acc = '{act, sel, comp, data, 8'd0};
        if (act == ACT_SET) begin
            latch_model = data;
        end else if (act == ACT_WRITE && comp != COMP_UNUSED) begin
            if (to_large)
                large_tab[latch_model][comp] = data;
            else
                small_tab[slot][comp] = {data[7:4], data[7:4]};
        end else if (act == ACT_READ && comp != COMP_UNUSED) begin
            if (to_large)
                acc.read_value = large_tab[latch_model][comp];
            else
                acc.read_value = small_tab[slot][comp] & NIBBLE_MASK;
        end
        read_values_due.push_back(acc);
    endtask

    // mostly short gaps, a few long ones, none while a burst is running
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // drive one command beat and wait until it is taken; called at a rising edge
    task automatic send_beat(input logic [1:0] act, input logic [1:0] sel,
                             input logic [1:0] comp, input logic [7:0] data);
        int gap;
        bit taken;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_action         <= act;
        i_palette_select <= sel;
        i_component      <= comp;
        i_data           <= data;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
        predict_access(act, sel, comp, data);
    endtask

    // result checker: every strobed beat against the oldest queued value
    always @(negedge i_clk) begin
        t_palette_access acc;
        if (o_result_strobe) begin
            if (read_values_due.size() == 0) begin
                report_mismatch($sformatf("result %0h with nothing outstanding", o_read_value));
            end else begin
                acc = read_values_due.pop_front();
                if (o_read_value !== acc.read_value)
                    report_mismatch($sformatf(
                        "act %0d sel %0d comp %0d data %02h: read_value %02h, want %02h",
                        acc.action, acc.sel, acc.comp, acc.data, o_read_value,
                        acc.read_value));
            end
        end
    end

    // defaults straight out of reset, extremes of the latch, black entry 8
    task automatic test_reset_values();
        send_beat(ACT_READ, SEL_LAYER0, COMP_RED, 8'h00);
        send_beat(ACT_SET, SEL_LAYER0, COMP_RED, 8'hFF);
        send_beat(ACT_READ, SEL_LARGE, COMP_BLUE, 8'h00);
        send_beat(ACT_READ, SEL_LAYER1, COMP_GREEN, 8'hFF);
        send_beat(ACT_SET, SEL_LARGE, COMP_GREEN, 8'h08);
        send_beat(ACT_READ, SEL_LAYER0, COMP_RED, 8'h00);
        send_beat(ACT_READ, SEL_LAYER1, COMP_BLUE, 8'h00);
        send_beat(ACT_SET, SEL_LAYER1, COMP_BLUE, 8'h07);
        send_beat(ACT_READ, SEL_LAYER0, COMP_GREEN, 8'hA5);
    endtask

    // nibble copy in both 16-color layers, full byte in the 256 table
    task automatic test_write_paths();
        send_beat(ACT_SET, SEL_LAYER0, COMP_RED, 8'hFF);
        send_beat(ACT_WRITE, SEL_LARGE_B, COMP_RED, 8'h00);
        send_beat(ACT_READ, SEL_LARGE, COMP_RED, 8'hFF);
        send_beat(ACT_WRITE, SEL_LAYER0, COMP_GREEN, 8'hA5);
        send_beat(ACT_READ, SEL_LAYER0, COMP_GREEN, 8'h00);
        send_beat(ACT_READ, SEL_LAYER1, COMP_GREEN, 8'h00);
        send_beat(ACT_WRITE, SEL_LAYER1, COMP_BLUE, 8'h3C);
        send_beat(ACT_READ, SEL_LAYER1, COMP_BLUE, 8'h00);
        send_beat(ACT_WRITE, SEL_LARGE, COMP_BLUE, 8'hFF);
        send_beat(ACT_READ, SEL_LARGE_B, COMP_BLUE, 8'h5A);
    endtask

    // unused action and component codes leave the tables alone and return zero
    task automatic test_unused_codes();
        send_beat(ACT_WRITE, SEL_LARGE, COMP_UNUSED, 8'h12);
        send_beat(ACT_READ, SEL_LARGE, COMP_UNUSED, 8'h00);
        send_beat(ACT_UNUSED, SEL_LAYER0, COMP_RED, 8'h55);
        send_beat(ACT_READ, SEL_LAYER0, COMP_RED, 8'h00);
        send_beat(ACT_READ, SEL_LARGE, COMP_RED, 8'h00);
    endtask

    // latch-set followed by a run of accesses to that entry, plus some noise
    task automatic test_random_traffic();
        int issued;
        int run_len;
        logic [1:0] run_sel;
        logic [1:0] sel;
        logic [1:0] comp;
        logic [7:0] idx;
        issued = 0;
        while (issued < RANDOM_BEATS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_beat(ACT_UNUSED, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                              8'($urandom_range(0, 255)));
                end else begin
                    send_beat(2'($urandom_range(0, 2)), 2'($urandom_range(0, 3)),
                              2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                    issued++;
                end
            end else begin
                case ($urandom_range(0, 9))
                    0: idx = 8'h00;
                    1: idx = 8'hFF;
                    2, 3: idx = 8'($urandom_range(0, 15));
                    default: idx = 8'($urandom_range(0, 255));
                endcase
                send_beat(ACT_SET, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), idx);
                issued++;
                run_sel = 2'($urandom_range(0, 3));
                run_len = $urandom_range(1, 6);
                repeat (run_len) begin
                    sel  = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : run_sel;
                    comp = ($urandom_range(0, 11) == 0) ? COMP_UNUSED
                                                        : 2'($urandom_range(0, 2));
                    send_beat(($urandom_range(0, 1) == 0) ? ACT_WRITE : ACT_READ, sel, comp,
                              8'($urandom_range(0, 255)));
                    issued++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // main sequence
    initial begin
        int waited;
        reset_palette_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_write_paths();
        test_unused_codes();
        test_random_traffic();

        // drain: wait for outstanding beats, then check that none is left
        start <= 1'b0;
        waited = 0;
        while (read_values_due.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (read_values_due.size() > 0)
            report_mismatch($sformatf("%0d results never arrived", read_values_due.size()));

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
